>>> rtl/core/dbd_pkg.sv
// Shared widths, limits and calendar tables for the day-difference block.
// No dependencies; used by days_between_dates_top and dbd_checker.
`default_nettype none

package dbd_pkg;

    // Field widths of the request and the response.
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 22;

    // Day numbers from 1 January of year 1 fit in 23 bits for any 14-bit year.
    localparam int unsigned DNUM_W = 23;

    // Last year that is accepted as valid.
    localparam int unsigned MAX_YEAR = 9999;

    // Largest count that the response field can carry.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Reciprocal of 100 scaled by 2^19; exact for all 14-bit dividends.
    localparam int unsigned DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_MUL   = 13'd5243;

    // Month codes that matter to the calendar rules.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Days before the first of a month in a common year.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [8:0] days;
        unique case (month)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Length of a month, with the leap day added to February.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/days_between_dates_top.sv
// Whole days between two Gregorian dates, as a four-stage pipeline.
// Depends on dbd_pkg for widths, limits and calendar tables.
//
// Usage:
//   A request carries two dates (day, month, year). It is taken at a rising
//   edge of clk where req_valid is high and req_stall is low. Each request
//   gives exactly one response on the res_ channel: day_count, the absolute
//   number of days between the dates, and bad_date, set when either date
//   has a month, day or year outside its range (day_count is then 0).
//   Counts above the width of day_count saturate.
//   A request passes through the stages in order before res_valid rises.
//   One request is taken in every cycle while req_stall is low, as each
//   of the four register stages hands on its contents while it loads new
//   ones. The stages hold the range checks and the year split by 100, the
//   leap test and day-number terms, the day-number sum, then the
//   difference with saturation.
//   When the receiver holds res_stall, the response stays on the port and
//   the stages behind it keep filling until every stage holds a request;
//   only then does req_stall rise. Nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) empties the pipeline; res_valid is low
//   and requests are taken in the first cycle after reset is released.
`default_nettype none

module days_between_dates_top
    import dbd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [DAY_W-1:0]   first_day,
    input  wire logic [MONTH_W-1:0] first_month,
    input  wire logic [YEAR_W-1:0]  first_year,
    input  wire logic [DAY_W-1:0]   second_day,
    input  wire logic [MONTH_W-1:0] second_month,
    input  wire logic [YEAR_W-1:0]  second_year,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [COUNT_W-1:0]      day_count,
    output logic                    bad_date
);

    // Pipeline valid bits and per-stage readiness.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, res_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    // Request fields as two date lanes.
    logic [DAY_W-1:0]   day_in   [2];
    logic [MONTH_W-1:0] month_in [2];
    logic [YEAR_W-1:0]  year_in  [2];

    // Stage 1: elapsed years and their hundreds.
    logic [DAY_W-1:0]   s1_day_next   [2];
    logic [MONTH_W-1:0] s1_month_next [2];
    logic [YEAR_W-1:0]  s1_p_next     [2];
    logic [7:0]         s1_q_next     [2];
    logic               s1_ok_next    [2];
    logic [DAY_W-1:0]   s1_day_reg    [2];
    logic [MONTH_W-1:0] s1_month_reg  [2];
    logic [YEAR_W-1:0]  s1_p_reg      [2];
    logic [7:0]         s1_q_reg      [2];
    logic               s1_ok_reg     [2];

    // Stage 2: year-based day count and day-of-year offset.
    logic [DNUM_W-1:0]  s2_base_next  [2];
    logic [8:0]         s2_small_next [2];
    logic               s2_ok_next    [2];
    logic [DNUM_W-1:0]  s2_base_reg   [2];
    logic [8:0]         s2_small_reg  [2];
    logic               s2_ok_reg     [2];

    // Stage 3: full day numbers.
    logic [DNUM_W-1:0]  s3_num_next [2];
    logic               s3_bad_next;
    logic [DNUM_W-1:0]  s3_num_reg  [2];
    logic               s3_bad_reg;

    // Stage 4: response.
    logic [COUNT_W-1:0] day_count_next;
    logic [COUNT_W-1:0] day_count_reg;
    logic               bad_date_reg;

    // A stage may load when it is empty or its contents move on.
    assign s4_ready  = !res_valid_reg || !res_stall;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_stall = !s1_ready;

    assign day_in[0]   = first_day;
    assign day_in[1]   = second_day;
    assign month_in[0] = first_month;
    assign month_in[1] = second_month;
    assign year_in[0]  = first_year;
    assign year_in[1]  = second_year;

    // Stage 1 logic: range checks and division of the elapsed years by 100.
    always_comb
    begin
        logic [26:0] prod;
        for (int i = 0; i < 2; i++)
        begin
            s1_day_next[i]   = day_in[i];
            s1_month_next[i] = month_in[i];
            s1_p_next[i]     = year_in[i] - YEAR_W'(1);
            prod             = 27'(s1_p_next[i]) * 27'(DIV100_MUL);
            s1_q_next[i]     = prod[DIV100_SHIFT +: 8];
            s1_ok_next[i]    = (month_in[i] >= MONTH_JAN) && (month_in[i] <= MONTH_DEC)
                               && (year_in[i] != '0) && (32'(year_in[i]) <= MAX_YEAR)
                               && (day_in[i] != '0);
        end
    end

    // Stage 2 logic: leap test, day check and the terms of the day number.
    always_comb
    begin
        logic [YEAR_W-1:0] rem;
        logic              leap;
        for (int i = 0; i < 2; i++)
        begin
            // The year is p + 1: divisible by 100 when p leaves 99.
            rem  = s1_p_reg[i] - (YEAR_W'(s1_q_reg[i]) * YEAR_W'(100));
            leap = (s1_p_reg[i][1:0] == 2'b11)
                   && ((rem != YEAR_W'(99)) || (s1_q_reg[i][1:0] == 2'b11));
            s2_ok_next[i]   = s1_ok_reg[i]
                              && (s1_day_reg[i] <= month_length(s1_month_reg[i], leap));
            s2_base_next[i] = DNUM_W'(s1_p_reg[i]) * DNUM_W'(365)
                              + DNUM_W'(s1_p_reg[i][YEAR_W-1:2])
                              + DNUM_W'(s1_q_reg[i][7:2])
                              - DNUM_W'(s1_q_reg[i]);
            s2_small_next[i] = days_before_month(s1_month_reg[i])
                               + 9'(leap && (s1_month_reg[i] > MONTH_FEB))
                               + 9'(s1_day_reg[i]) - 9'd1;
        end
    end

    // Stage 3 logic: add the two parts of each day number.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s3_num_next[i] = s2_base_reg[i] + DNUM_W'(s2_small_reg[i]);
        end
        s3_bad_next = !(s2_ok_reg[0] && s2_ok_reg[1]);
    end

    // Stage 4 logic: absolute difference with saturation.
    always_comb
    begin
        logic [DNUM_W-1:0] diff;
        if (s3_num_reg[0] >= s3_num_reg[1])
        begin
            diff = s3_num_reg[0] - s3_num_reg[1];
        end
        else
        begin
            diff = s3_num_reg[1] - s3_num_reg[0];
        end
        if (s3_bad_reg)
        begin
            day_count_next = '0;
        end
        else if (diff > DNUM_W'(COUNT_MAX))
        begin
            day_count_next = COUNT_MAX;
        end
        else
        begin
            day_count_next = diff[COUNT_W-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload registers, loaded whenever their stage may take new contents.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (s1_ready)
            begin
                s1_day_reg[i]   <= s1_day_next[i];
                s1_month_reg[i] <= s1_month_next[i];
                s1_p_reg[i]     <= s1_p_next[i];
                s1_q_reg[i]     <= s1_q_next[i];
                s1_ok_reg[i]    <= s1_ok_next[i];
            end
            if (s2_ready)
            begin
                s2_base_reg[i]  <= s2_base_next[i];
                s2_small_reg[i] <= s2_small_next[i];
                s2_ok_reg[i]    <= s2_ok_next[i];
            end
            if (s3_ready)
            begin
                s3_num_reg[i] <= s3_num_next[i];
            end
        end
        if (s3_ready)
        begin
            s3_bad_reg <= s3_bad_next;
        end
        if (s4_ready)
        begin
            day_count_reg <= day_count_next;
            bad_date_reg  <= s3_bad_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign day_count = day_count_reg;
    assign bad_date  = bad_date_reg;

endmodule

`default_nettype wire

>>> rtl/core/dbd_checker.sv
// Port-level checks for days_between_dates_top, attached by a bind below.
// Depends on dbd_pkg for field widths.
`default_nettype none

module dbd_checker
    import dbd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire logic [COUNT_W-1:0] day_count,
    input wire logic               bad_date
);

    // A stalled response holds its place and its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(day_count) && $stable(bad_date))
        else $error("stalled response changed or vanished");

    // A bad date always reports a count of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_date |-> day_count == '0)
        else $error("bad date with a non-zero count");

    // With the receiver taking responses, a request comes out once it has passed every stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall
        |=> res_valid)
        else $error("response missing four cycles after the request");

    // Reset empties the pipeline.
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("response shown during reset");

endmodule

bind days_between_dates_top dbd_checker u_dbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .day_count (day_count),
    .bad_date  (bad_date)
);

`default_nettype wire
